FILE: rtl/asd_pkg.sv
// Shared types and constants of the accelerometer shake detector.
`timescale 1ns / 1ps
package asd_pkg;

	localparam int AXIS_W  = 16;
	localparam int PREV_W  = 8;
	localparam int DIST_W  = 18;
	localparam int LIMIT_W = 16;
	localparam int COUNT_W = 17;
	localparam int TIME_W  = 48;
	localparam int CFG_W   = 48;

	localparam logic signed [AXIS_W-1:0] AXIS_MIN = -16'sd128;
	localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sd127;

	localparam logic [DIST_W-1:0]  THRESHOLD_RESET   = 18'(110 * 110 + 80 * 80 + 30 * 30);
	localparam logic [LIMIT_W-1:0] QUIET_LIMIT_RESET = 16'd20;
	localparam logic [TIME_W-1:0]  MIN_DURATION_RESET = '0;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		REG_THRESHOLD    = 2'd0,
		REG_QUIET_LIMIT  = 2'd1,
		REG_MIN_DURATION = 2'd2
	} reg_index_t;

	localparam logic EVENT_START = 1'b0;
	localparam logic EVENT_END   = 1'b1;

	typedef struct packed {
		logic shake_event;
		logic long_enough;
	} result_t;

endpackage

FILE: rtl/asd_sample_if.sv
// Stream interface carrying accelerometer samples with their timestamps.
`timescale 1ns / 1ps
interface asd_sample_if;
	logic                             valid;
	logic                             ready;
	logic signed [asd_pkg::AXIS_W-1:0] axis_x;
	logic signed [asd_pkg::AXIS_W-1:0] axis_y;
	logic signed [asd_pkg::AXIS_W-1:0] axis_z;
	logic [asd_pkg::TIME_W-1:0]        timestamp_us;

	modport source (output valid, axis_x, axis_y, axis_z, timestamp_us, input ready);
	modport sink (input valid, axis_x, axis_y, axis_z, timestamp_us, output ready);
endinterface

FILE: rtl/asd_event_if.sv
// Stream interface carrying shake start and end events.
`timescale 1ns / 1ps
interface asd_event_if;
	logic valid;
	logic ready;
	logic shake_event;
	logic long_enough;

	modport source (output valid, shake_event, long_enough, input ready);
	modport sink (input valid, shake_event, long_enough, output ready);
endinterface

FILE: rtl/asd_cfg_if.sv
// Register write interface of the shake detector.
`timescale 1ns / 1ps
interface asd_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                index;
	logic [asd_pkg::CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/accel_shake_detector.sv
// Top level of the accelerometer shake detector.
`timescale 1ns / 1ps
// The detector takes one sample transfer in every clock cycle. A sample with an axis outside
// -128..127 is dropped at the input. Each kept sample is held in one input register and is
// evaluated in the following cycle, where the squared distance, threshold compare, quiet
// counter and elapsed-time check update the detector state; a start or end event then enters
// a two-entry output queue and is offered on the event channel from that queue, so it passes
// the input register and the queue in turn. The input stalls only while that queue is full,
// no event leaves it and the held sample would add another event. Register writes are always
// accepted and take effect at once; they should be made while no sample is in flight.
module accel_shake_detector (
	input  logic                clk,
	input  logic                arst_n,
	asd_cfg_if.sink             cfg,
	asd_sample_if.sink          samples,
	asd_event_if.source         events
);

	logic [asd_pkg::DIST_W-1:0]  threshold_q;
	logic [asd_pkg::LIMIT_W-1:0] quiet_limit_q;
	logic [asd_pkg::TIME_W-1:0]  min_duration_q;

	logic                               awaiting_first_q;
	logic signed [asd_pkg::PREV_W-1:0]  prev_x_q;
	logic signed [asd_pkg::PREV_W-1:0]  prev_y_q;
	logic signed [asd_pkg::PREV_W-1:0]  prev_z_q;
	logic                               shaking_q;
	logic [asd_pkg::COUNT_W-1:0]        quiet_count_q;
	logic [asd_pkg::TIME_W-1:0]         start_time_q;

	logic                               valid_s1;
	logic signed [asd_pkg::PREV_W-1:0]  x_s1;
	logic signed [asd_pkg::PREV_W-1:0]  y_s1;
	logic signed [asd_pkg::PREV_W-1:0]  z_s1;
	logic [asd_pkg::TIME_W-1:0]         ts_s1;

	asd_pkg::result_t fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fifo_count_q;

	logic                         in_range;
	logic                         accept;
	logic                         advance;
	logic                         fifo_full;
	logic                         pop;
	logic                         push;
	logic signed [8:0]            dx;
	logic signed [8:0]            dy;
	logic signed [8:0]            dz;
	logic signed [17:0]           px;
	logic signed [17:0]           py;
	logic signed [17:0]           pz;
	logic [asd_pkg::DIST_W-1:0]   sq_dist;
	logic                         d_gt;
	logic                         d_lt;
	logic                         start;
	logic                         shaking_mid;
	logic [asd_pkg::COUNT_W-1:0]  count_mid;
	logic [asd_pkg::COUNT_W-1:0]  count_inc;
	logic                         finish;
	logic [asd_pkg::TIME_W-1:0]   elapsed;
	logic                         has_result;
	asd_pkg::result_t             result;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= asd_pkg::THRESHOLD_RESET;
			quiet_limit_q  <= asd_pkg::QUIET_LIMIT_RESET;
			min_duration_q <= asd_pkg::MIN_DURATION_RESET;
		end else if (cfg.valid) begin
			case (asd_pkg::reg_index_t'(cfg.index))
				asd_pkg::REG_THRESHOLD:    threshold_q    <= cfg.data[asd_pkg::DIST_W-1:0];
				asd_pkg::REG_QUIET_LIMIT:  quiet_limit_q  <= cfg.data[asd_pkg::LIMIT_W-1:0];
				asd_pkg::REG_MIN_DURATION: min_duration_q <= cfg.data[asd_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_range = samples.axis_x >= asd_pkg::AXIS_MIN && samples.axis_x <= asd_pkg::AXIS_MAX
		&& samples.axis_y >= asd_pkg::AXIS_MIN && samples.axis_y <= asd_pkg::AXIS_MAX
		&& samples.axis_z >= asd_pkg::AXIS_MIN && samples.axis_z <= asd_pkg::AXIS_MAX;

	// Squared distance to the previous sample and the shake decision.
	always_comb begin
		dx = {x_s1[7], x_s1} - {prev_x_q[7], prev_x_q};
		dy = {y_s1[7], y_s1} - {prev_y_q[7], prev_y_q};
		dz = {z_s1[7], z_s1} - {prev_z_q[7], prev_z_q};
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
		sq_dist = asd_pkg::DIST_W'(px[16:0]) + asd_pkg::DIST_W'(py[16:0])
			+ asd_pkg::DIST_W'(pz[16:0]);
		d_gt = sq_dist > threshold_q;
		d_lt = sq_dist < threshold_q;
		start = !awaiting_first_q && !shaking_q && d_gt;
		shaking_mid = shaking_q || d_gt;
		count_mid = d_gt ? '0 : quiet_count_q;
		count_inc = (count_mid == asd_pkg::COUNT_MAX) ? count_mid : count_mid + 1'b1;
		finish = !awaiting_first_q && shaking_mid && d_lt
			&& count_inc > asd_pkg::COUNT_W'(quiet_limit_q);
		elapsed = ts_s1 - start_time_q;
		has_result = start || finish;
		result.shake_event = finish ? asd_pkg::EVENT_END : asd_pkg::EVENT_START;
		result.long_enough = finish && (elapsed >= min_duration_q);
	end

	assign pop       = events.valid && events.ready;
	assign fifo_full = fifo_count_q == 2'd2;
	assign advance   = valid_s1 && (!has_result || !fifo_full || pop);
	assign push      = advance && has_result;
	assign samples.ready = !valid_s1 || advance;
	assign accept    = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= samples.axis_x[asd_pkg::PREV_W-1:0];
			y_s1  <= samples.axis_y[asd_pkg::PREV_W-1:0];
			z_s1  <= samples.axis_z[asd_pkg::PREV_W-1:0];
			ts_s1 <= samples.timestamp_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_first_q <= 1'b1;
			prev_x_q         <= '0;
			prev_y_q         <= '0;
			prev_z_q         <= '0;
			shaking_q        <= 1'b0;
			quiet_count_q    <= '0;
			start_time_q     <= '0;
		end else if (advance) begin
			awaiting_first_q <= 1'b0;
			prev_x_q         <= x_s1;
			prev_y_q         <= y_s1;
			prev_z_q         <= z_s1;
			if (!awaiting_first_q) begin
				shaking_q <= shaking_mid && !finish;
				if (finish) begin
					quiet_count_q <= '0;
				end else if (shaking_mid) begin
					quiet_count_q <= count_inc;
				end else begin
					quiet_count_q <= count_mid;
				end
				if (start) begin
					start_time_q <= ts_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			fifo_count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fifo_count_q <= fifo_count_q + 2'd1;
			end else if (pop && !push) begin
				fifo_count_q <= fifo_count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= result;
		end
	end

	assign events.valid       = fifo_count_q != 2'd0;
	assign events.shake_event = fifo_q[rd_ptr_q].shake_event;
	assign events.long_enough = fifo_q[rd_ptr_q].long_enough;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for accel_shake_detector: predicted shake events against the block.
`timescale 1ns / 1ps
module testbench;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT = 5000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int LONG_RUN_SAMPLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 130;
	localparam logic [asd_pkg::CFG_W-1:0] ALL_ONES = '1;

	class shake_scoreboard;
		logic [asd_pkg::DIST_W-1:0]          threshold;
		logic [asd_pkg::LIMIT_W-1:0]         quiet_limit;
		logic [asd_pkg::TIME_W-1:0]          min_duration;
		bit                                  primed;
		logic signed [asd_pkg::PREV_W-1:0]   last_x, last_y, last_z;
		bit                                  active;
		logic [asd_pkg::COUNT_W-1:0]         quiet_reads;
		logic [asd_pkg::TIME_W-1:0]          start_time;
		asd_pkg::result_t                    expected[$];
		int                                  failures;
		int                                  ignored;
		int                                  starts_checked;
		int                                  ends_checked;

		function new();
			threshold = asd_pkg::THRESHOLD_RESET;
			quiet_limit = asd_pkg::QUIET_LIMIT_RESET;
			min_duration = asd_pkg::MIN_DURATION_RESET;
			primed = 1'b0;
			last_x = '0;
			last_y = '0;
			last_z = '0;
			active = 1'b0;
			quiet_reads = '0;
			start_time = '0;
			failures = 0;
			ignored = 0;
			starts_checked = 0;
			ends_checked = 0;
		endfunction

		function void report(string what);
			failures++;
			if (failures <= 10)
				$display("MISMATCH at %0t: %s", $realtime, what);
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void apply_write(logic [1:0] idx, logic [asd_pkg::CFG_W-1:0] value);
			case (idx)
				asd_pkg::REG_THRESHOLD: threshold = value[asd_pkg::DIST_W-1:0];
				asd_pkg::REG_QUIET_LIMIT: quiet_limit = value[asd_pkg::LIMIT_W-1:0];
				asd_pkg::REG_MIN_DURATION: min_duration = value[asd_pkg::TIME_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic signed [asd_pkg::AXIS_W-1:0] x,
				logic signed [asd_pkg::AXIS_W-1:0] y,
				logic signed [asd_pkg::AXIS_W-1:0] z, logic [asd_pkg::TIME_W-1:0] ts);
			int dx, dy, dz, sq_dist;
			logic [asd_pkg::TIME_W-1:0] elapsed;
			asd_pkg::result_t r;
			if (x < asd_pkg::AXIS_MIN || x > asd_pkg::AXIS_MAX ||
					y < asd_pkg::AXIS_MIN || y > asd_pkg::AXIS_MAX ||
					z < asd_pkg::AXIS_MIN || z > asd_pkg::AXIS_MAX) begin
				ignored++;
				return;
			end
			if (!primed) begin
				primed = 1'b1;
			end else begin
				dx = int'(x) - int'(last_x);
				dy = int'(y) - int'(last_y);
				dz = int'(z) - int'(last_z);
				sq_dist = dx * dx + dy * dy + dz * dz;
				if (sq_dist > int'(threshold)) begin
					if (!active) begin
						active = 1'b1;
						start_time = ts;
						r.shake_event = asd_pkg::EVENT_START;
						r.long_enough = 1'b0;
						expected.push_back(r);
					end
					quiet_reads = '0;
				end
				if (active) begin
					if (quiet_reads != asd_pkg::COUNT_MAX)
						quiet_reads++;
					if (sq_dist < int'(threshold) && quiet_reads > quiet_limit) begin
						elapsed = ts - start_time;
						r.shake_event = asd_pkg::EVENT_END;
						r.long_enough = (elapsed >= min_duration);
						expected.push_back(r);
						active = 1'b0;
						quiet_reads = '0;
					end
				end
			end
			last_x = x[asd_pkg::PREV_W-1:0];
			last_y = y[asd_pkg::PREV_W-1:0];
			last_z = z[asd_pkg::PREV_W-1:0];
		endfunction

		function void check_event(logic shake_event, logic long_enough);
			asd_pkg::result_t want;
			if (expected.size() == 0) begin
				report($sformatf("event %b/%b with none expected", shake_event, long_enough));
				return;
			end
			want = expected.pop_front();
			if (shake_event !== want.shake_event)
				report($sformatf("shake_event expected %b, got %b",
					want.shake_event, shake_event));
			if (long_enough !== want.long_enough)
				report($sformatf("long_enough expected %b, got %b",
					want.long_enough, long_enough));
			if (want.shake_event == asd_pkg::EVENT_END)
				ends_checked++;
			else
				starts_checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	asd_cfg_if    cfg_bus();
	asd_sample_if sample_bus();
	asd_event_if  event_bus();

	accel_shake_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.samples(sample_bus),
		.events(event_bus)
	);

	shake_scoreboard sb = new();
	int holdoff_left = 0;
	int samples_sent = 0;
	int cur_x, cur_y, cur_z;
	logic [asd_pkg::TIME_W-1:0] clock_us;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (event_bus.valid && event_bus.ready)
			sb.check_event(event_bus.shake_event, event_bus.long_enough);
	end

	// The receiver changes its stall pattern in windows of random length.
	initial begin
		int mode, window, pattern_cnt;
		event_bus.ready = 1'b0;
		mode = 0;
		window = 0;
		pattern_cnt = 0;
		forever begin
			@(negedge clk);
			if (window == 0) begin
				mode = $urandom_range(0, 3);
				window = $urandom_range(16, 96);
			end
			window--;
			pattern_cnt++;
			if (holdoff_left > 0) begin
				event_bus.ready = 1'b0;
				holdoff_left--;
			end else begin
				case (mode)
					2: event_bus.ready = (pattern_cnt % 3 != 0);
					3: event_bus.ready = $urandom_range(0, 1);
					default: event_bus.ready = 1'b1;
				endcase
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Timeout: the run did not complete.");
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [asd_pkg::TIME_W-1:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic int clamp_axis(int v);
		if (v > 127)
			return 127;
		if (v < -128)
			return -128;
		return v;
	endfunction

	task automatic set_register(input logic [1:0] idx, input logic [asd_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data = value;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.apply_write(idx, value);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic send_sample(input int x, input int y, input int z,
			input logic [asd_pkg::TIME_W-1:0] ts);
		@(negedge clk);
		sample_bus.valid = 1'b1;
		sample_bus.axis_x = 16'(x);
		sample_bus.axis_y = 16'(y);
		sample_bus.axis_z = 16'(z);
		sample_bus.timestamp_us = ts;
		do @(posedge clk); while (!sample_bus.ready);
		sb.note_sample(sample_bus.axis_x, sample_bus.axis_y, sample_bus.axis_z,
			sample_bus.timestamp_us);
		samples_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		sample_bus.valid = 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && sb.pending() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int phase_no, input int items);
		int roll, k, wild, nx, ny, nz, burst_left, gap;
		logic [asd_pkg::CFG_W-1:0] thr_data, limit_data, min_data;
		case (phase_no % 4)
			0: thr_data = $urandom_range(20, 400);
			1: thr_data = $urandom_range(400, 5000);
			2: thr_data = $urandom_range(5000, 40000);
			default: thr_data = rand48();
		endcase
		if (phase_no == 7)
			limit_data = rand48();
		else if (phase_no % 3 == 2)
			limit_data = $urandom_range(5, 30);
		else
			limit_data = $urandom_range(0, 4);
		if (phase_no == 5)
			min_data = rand48();
		else if (phase_no % 2 == 1)
			min_data = $urandom_range(0, 300);
		else
			min_data = '0;
		set_register(asd_pkg::REG_THRESHOLD, thr_data);
		set_register(asd_pkg::REG_QUIET_LIMIT, limit_data);
		set_register(asd_pkg::REG_MIN_DURATION, min_data);
		burst_left = $urandom_range(1, 24);
		for (int i = 0; i < items; i++) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 49) == 0)
				clock_us = rand48();
			else
				clock_us = clock_us + $urandom_range(1, 60);
			if (roll < 8) begin
				// Out-of-range noise on one axis; the block must drop it.
				nx = int'($urandom_range(0, 255)) - 128;
				ny = int'($urandom_range(0, 255)) - 128;
				nz = int'($urandom_range(0, 255)) - 128;
				wild = $urandom_range(128, 32767);
				if ($urandom_range(0, 1))
					wild = -wild - 1;
				k = $urandom_range(0, 2);
				case (k)
					0: nx = wild;
					1: ny = wild;
					default: nz = wild;
				endcase
				send_sample(nx, ny, nz, clock_us);
			end else begin
				if (roll < 30) begin
					cur_x = int'($urandom_range(0, 255)) - 128;
					cur_y = int'($urandom_range(0, 255)) - 128;
					cur_z = int'($urandom_range(0, 255)) - 128;
				end else begin
					cur_x = clamp_axis(cur_x + int'($urandom_range(0, 6)) - 3);
					cur_y = clamp_axis(cur_y + int'($urandom_range(0, 6)) - 3);
					cur_z = clamp_axis(cur_z + int'($urandom_range(0, 6)) - 3);
				end
				send_sample(cur_x, cur_y, cur_z, clock_us);
			end
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(0, 6);
				repeat (gap) begin
					@(negedge clk);
					sample_bus.valid = 1'b0;
				end
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = asd_pkg::REG_THRESHOLD;
		cfg_bus.data = '0;
		sample_bus.valid = 1'b0;
		sample_bus.axis_x = '0;
		sample_bus.axis_y = '0;
		sample_bus.axis_z = '0;
		sample_bus.timestamp_us = '0;
		cur_x = 0;
		cur_y = 0;
		cur_z = 0;
		clock_us = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: dropped samples, priming, distance equal to the threshold, start.
		send_sample(-32768, 0, 0, 48'h0);
		send_sample(0, 32767, 0, 48'h0);
		send_sample(0, 0, -129, 48'h1);
		send_sample(0, 0, 128, 48'h1);
		send_sample(0, 0, 0, 48'h0);
		send_sample(110, 80, 30, 48'hA);
		send_sample(-128, -128, -128, 48'hFFFF_FFFF_FF00);
		send_sample(127, 127, 127, 48'hFFFF_FFFF_FF80);
		drain();

		// End across a timestamp wrap, elapsed equal to the minimum, equal distance mid-shake.
		set_register(asd_pkg::REG_QUIET_LIMIT, 48'd0);
		set_register(asd_pkg::REG_MIN_DURATION, 48'd1000);
		send_sample(127, 127, 127, 48'h100);
		send_sample(-128, 127, -128, 48'h1000);
		send_sample(-128, 127, -128, 48'h1000 + 48'd1000);
		send_sample(0, 0, 0, 48'h2000);
		send_sample(110, 80, 30, 48'h2001);
		send_sample(110, 80, 30, 48'h2002);
		drain();

		set_register(asd_pkg::REG_MIN_DURATION, ALL_ONES);
		send_sample(-128, -128, -128, 48'h1);
		send_sample(-128, -128, -128, 48'h0);
		drain();

		// With a zero threshold no sample can end a shake, so the shake runs on for a while.
		set_register(asd_pkg::REG_THRESHOLD, 48'd0);
		set_register(asd_pkg::REG_QUIET_LIMIT, ALL_ONES);
		send_sample(127, 127, 127, 48'd100);
		for (int i = 1; i <= LONG_RUN_SAMPLES; i++)
			send_sample(127, 127, 127, 48'd100 + i);
		drain();
		set_register(asd_pkg::REG_THRESHOLD, ALL_ONES);
		set_register(REG_SPARE, 48'd0);
		send_sample(126, 127, 127, 48'd200000);
		drain();

		// After the first, every sample makes an event while the receiver holds off, so the input backs up.
		set_register(asd_pkg::REG_THRESHOLD, 48'd100);
		set_register(asd_pkg::REG_QUIET_LIMIT, 48'd0);
		set_register(asd_pkg::REG_MIN_DURATION, 48'd50);
		holdoff_left = HOLDOFF_CYCLES;
		clock_us = 48'd300000;
		for (int i = 0; i < 60; i++) begin
			clock_us = clock_us + 10;
			if (i % 4 < 2)
				send_sample(-128, -128, -128, clock_us);
			else
				send_sample(127, 127, 127, clock_us);
		end
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++)
			random_phase(p, PHASE_SAMPLES);

		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected events never arrived", sb.pending()));
		$display("Run summary: %0d samples transferred, %0d of them out of range and dropped.",
			samples_sent, sb.ignored);
		$display("Checked %0d shake starts and %0d shake ends; %0d mismatches.",
			sb.starts_checked, sb.ends_checked, sb.failures);
		if (sb.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
